>>> hw/rtl/wti_pkg.sv
// Shared constants, types and control structures of the waypoint trajectory interpolator.
package wti_pkg;

    // Table dimensions.
    localparam int MAX_POINTS = 64;
    localparam int MAX_JOINTS = 8;

    localparam int PT_W      = $clog2(MAX_POINTS);
    localparam int JNT_W     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int NP_W      = $clog2(MAX_POINTS + 1);
    localparam int NJ_W      = $clog2(MAX_JOINTS + 1);
    localparam int PA_W      = PT_W + JNT_W;
    localparam int POS_DEPTH = MAX_POINTS << JNT_W;

    // Item and register field widths.
    localparam int CMD_W     = 2;
    localparam int PIDX_W    = 6;
    localparam int JIDX_W    = 3;
    localparam int VAL_W     = 32;
    localparam int NPR_W     = 7;
    localparam int NJR_W     = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Fraction and divider.
    localparam int FRAC_W    = 17;
    localparam int QUO_W     = 16;
    localparam int DCNT_W    = $clog2(QUO_W);
    localparam int WIDE_W    = VAL_W + 1;
    localparam int PROD_W    = WIDE_W + FRAC_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_TIME = 2'd0,
        CMD_WR_POS  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_SAMPLE  = 2'd3
    } cmd_t;

    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
    typedef logic [CFG_W-1:0]        cfg_data_t;
    typedef logic [NPR_W-1:0]        npr_t;
    typedef logic [NJR_W-1:0]        njr_t;
    typedef logic [PIDX_W-1:0]       pidx_t;
    typedef logic [JIDX_W-1:0]       jidx_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [WIDE_W-1:0]       rem_t;
    typedef logic [PT_W-1:0]         pt_t;
    typedef logic [JNT_W-1:0]        jn_t;
    typedef logic [NP_W-1:0]         np_t;
    typedef logic [NJ_W-1:0]         nj_t;
    typedef logic [PA_W-1:0]         paddr_t;
    typedef logic [FRAC_W-1:0]       frac_t;
    typedef logic [DCNT_W-1:0]       dcnt_t;

    localparam cfg_idx_t CFG_NUM_POINTS = 1'b0;
    localparam cfg_idx_t CFG_NUM_JOINTS = 1'b1;
    localparam npr_t     NP_RESET       = 7'd2;
    localparam njr_t     NJ_RESET       = 4'd6;
    localparam frac_t    FRAC_ONE       = 17'h1_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;      // input channel open
        logic fin_start;  // sample past the last segment: emit the final waypoint
        logic t_next;     // time read address is segment + 1
        logic seg_inc;    // advance the segment
        logic t0_cap;     // capture start time
        logic nd_cap;     // capture numerator and denominator
        logic frac_sel;   // pick the fraction or start the divider
        logic div_step;   // one quotient bit
        logic p_next;     // position read address uses segment + 1
        logic p0_cap;     // capture start position
        logic p1_cap;     // capture position difference
        logic mul;        // form the scaled difference
        logic out_load;   // load the output register
        logic j_inc;      // next joint
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sample;
        logic final_now;
        logic adv_gt;
        logic adv_more;
        logic div_need;
        logic div_last;
        logic out_free;
        logic j_last;
    } stat_t;

endpackage

>>> hw/rtl/wti_in_if.sv
// Input channel of the interpolator: valid/ready handshake with the command payload.
interface wti_in_if;
    logic                          valid;
    logic                          ready;
    logic [wti_pkg::CMD_W-1:0]     command;
    logic [wti_pkg::PIDX_W-1:0]    point_index;
    logic [wti_pkg::JIDX_W-1:0]    joint_index;
    logic signed [wti_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output point_index,
                    output joint_index, output value, input ready);
    modport sink   (input valid, input command, input point_index,
                    input joint_index, input value, output ready);
endinterface

>>> hw/rtl/wti_out_if.sv
// Output channel of the interpolator: valid/ready handshake with one joint target.
interface wti_out_if;
    logic                             valid;
    logic                             ready;
    logic [wti_pkg::JIDX_W-1:0]       out_joint;
    logic signed [wti_pkg::VAL_W-1:0] target_position;
    logic                             last_joint;
    logic                             finished;

    modport source (output valid, output out_joint, output target_position,
                    output last_joint, output finished, input ready);
    modport sink   (input valid, input out_joint, input target_position,
                    input last_joint, input finished, output ready);
endinterface

>>> hw/rtl/wti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wti_ctrl.sv
// Controller state machine of the interpolator: sequences advance, divide and per-joint lerp.
module wti_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  wti_pkg::stat_t  st,
    output wti_pkg::ctrl_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADV_RD,
        S_ADV_CMP,
        S_T0_RD,
        S_T1_RD,
        S_T1_CAP,
        S_FRAC_SEL,
        S_DIV,
        S_J_RD0,
        S_J_RD1,
        S_J_CAP1,
        S_J_MUL,
        S_J_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctl.ready = 1'b1;
                if (in_valid && st.is_sample)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.final_now)
                begin
                    ctl.fin_start = 1'b1;
                    state_next    = S_J_RD0;
                end
                else
                begin
                    state_next = S_ADV_RD;
                end
            end
            S_ADV_RD:
            begin
                ctl.t_next = 1'b1;
                state_next = S_ADV_CMP;
            end
            S_ADV_CMP:
            begin
                if (st.adv_gt)
                begin
                    ctl.seg_inc = 1'b1;
                    state_next  = st.adv_more ? S_ADV_RD : S_T0_RD;
                end
                else
                begin
                    state_next = S_T0_RD;
                end
            end
            S_T0_RD:
            begin
                state_next = S_T1_RD;
            end
            S_T1_RD:
            begin
                ctl.t_next = 1'b1;
                ctl.t0_cap = 1'b1;
                state_next = S_T1_CAP;
            end
            S_T1_CAP:
            begin
                ctl.nd_cap = 1'b1;
                state_next = S_FRAC_SEL;
            end
            S_FRAC_SEL:
            begin
                ctl.frac_sel = 1'b1;
                state_next   = st.div_need ? S_DIV : S_J_RD0;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_J_RD0;
                end
            end
            S_J_RD0:
            begin
                state_next = S_J_RD1;
            end
            S_J_RD1:
            begin
                ctl.p_next = 1'b1;
                ctl.p0_cap = 1'b1;
                state_next = S_J_CAP1;
            end
            S_J_CAP1:
            begin
                ctl.p1_cap = 1'b1;
                state_next = S_J_MUL;
            end
            S_J_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_J_OUT;
            end
            S_J_OUT:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    if (st.j_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.j_inc  = 1'b1;
                        state_next = S_J_RD0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/wti_dp.sv
// Datapath of the interpolator: waypoint memories, segment state, divider, lerp and output register.
module wti_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  wti_pkg::cfg_idx_t   cfg_index,
    input  wti_pkg::cfg_data_t  cfg_data,
    input  logic                in_valid,
    input  wti_pkg::pidx_t      point_index,
    input  wti_pkg::jidx_t      joint_index,
    input  logic [wti_pkg::CMD_W-1:0] command,
    input  wti_pkg::val_t       value,
    input  logic                out_ready,
    input  wti_pkg::ctrl_t      ctl,
    output wti_pkg::stat_t      st,
    output logic                out_valid,
    output wti_pkg::jidx_t      out_joint,
    output wti_pkg::val_t       target_position,
    output logic                last_joint,
    output logic                finished
);

    // Control state.
    wti_pkg::npr_t   np_reg;
    wti_pkg::njr_t   nj_reg;
    wti_pkg::pt_t    seg_reg;
    logic            done_reg;
    logic            fmode_reg;
    wti_pkg::jn_t    j_reg;
    wti_pkg::dcnt_t  dcnt_reg;
    logic            out_valid_reg;

    // Payload.
    wti_pkg::val_t   val_reg;
    wti_pkg::val_t   t0_reg;
    wti_pkg::wide_t  num_reg;
    wti_pkg::wide_t  den_reg;
    wti_pkg::rem_t   rem_reg;
    wti_pkg::frac_t  frac_reg;
    wti_pkg::val_t   p0_reg;
    wti_pkg::wide_t  delta_reg;
    wti_pkg::prod_t  prod_reg;
    wti_pkg::jidx_t  oj_reg;
    wti_pkg::val_t   opos_reg;
    logic            olast_reg;
    logic            ofin_reg;

    wti_pkg::cmd_t   cmd;
    logic            accept;
    logic            pidx_ok;
    logic            jidx_ok;
    wti_pkg::np_t    np_used;
    wti_pkg::nj_t    nj_used;
    wti_pkg::pt_t    last_seg;
    wti_pkg::pt_t    final_pt;
    wti_pkg::pt_t    seg_p1;
    wti_pkg::pt_t    p_pt;
    logic            t_we;
    logic            p_we;
    wti_pkg::pt_t    t_raddr;
    wti_pkg::paddr_t p_waddr;
    wti_pkg::paddr_t p_raddr;
    wti_pkg::val_t   t_rdata;
    wti_pkg::val_t   p_rdata;
    logic            j_last;
    logic            out_free;
    logic [wti_pkg::WIDE_W:0] div_sh;
    logic            div_ge;
    wti_pkg::wide_t  off;
    logic            rnd;
    wti_pkg::val_t   pos_next;

    assign cmd     = wti_pkg::cmd_t'(command);
    assign accept  = ctl.ready && in_valid;
    assign pidx_ok = int'(point_index) < wti_pkg::MAX_POINTS;
    assign jidx_ok = int'(joint_index) < wti_pkg::MAX_JOINTS;

    // Register values outside the supported range are clamped on use.
    always_comb
    begin
        if (np_reg < wti_pkg::npr_t'(2))
        begin
            np_used = wti_pkg::np_t'(2);
        end
        else if (int'(np_reg) > wti_pkg::MAX_POINTS)
        begin
            np_used = wti_pkg::np_t'(wti_pkg::MAX_POINTS);
        end
        else
        begin
            np_used = wti_pkg::np_t'(np_reg);
        end

        if (nj_reg < wti_pkg::njr_t'(1))
        begin
            nj_used = wti_pkg::nj_t'(1);
        end
        else if (int'(nj_reg) > wti_pkg::MAX_JOINTS)
        begin
            nj_used = wti_pkg::nj_t'(wti_pkg::MAX_JOINTS);
        end
        else
        begin
            nj_used = wti_pkg::nj_t'(nj_reg);
        end
    end

    assign last_seg = wti_pkg::pt_t'(np_used - wti_pkg::np_t'(2));
    assign final_pt = wti_pkg::pt_t'(np_used - wti_pkg::np_t'(1));
    assign seg_p1   = seg_reg + 1'b1;
    assign j_last   = wti_pkg::nj_t'(j_reg) == (nj_used - wti_pkg::nj_t'(1));
    assign out_free = !out_valid_reg || out_ready;

    // Memory ports.
    assign t_we    = accept && (cmd == wti_pkg::CMD_WR_TIME) && pidx_ok;
    assign p_we    = accept && (cmd == wti_pkg::CMD_WR_POS) && pidx_ok && jidx_ok;
    assign t_raddr = ctl.t_next ? seg_p1 : seg_reg;
    assign p_waddr = {wti_pkg::pt_t'(point_index), wti_pkg::jn_t'(joint_index)};
    assign p_pt    = ctl.p_next ? seg_p1 : (fmode_reg ? final_pt : seg_reg);
    assign p_raddr = {p_pt, j_reg};

    wti_ram #(
        .WIDTH (wti_pkg::VAL_W),
        .DEPTH (wti_pkg::MAX_POINTS)
    ) u_times (
        .clk   (clk),
        .we    (t_we),
        .waddr (wti_pkg::pt_t'(point_index)),
        .wdata (value),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    wti_ram #(
        .WIDTH (wti_pkg::VAL_W),
        .DEPTH (wti_pkg::POS_DEPTH)
    ) u_positions (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (value),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Restoring divider: one quotient bit per step.
    assign div_sh = {rem_reg, 1'b0};
    assign div_ge = div_sh >= {1'b0, den_reg};

    // Truncation toward zero of the scaled difference, then the offset from p0.
    assign off      = wti_pkg::wide_t'(prod_reg >>> wti_pkg::QUO_W);
    assign rnd      = prod_reg[wti_pkg::PROD_W-1] && (|prod_reg[wti_pkg::QUO_W-1:0]);
    assign pos_next = wti_pkg::val_t'(wti_pkg::wide_t'(p0_reg) + off
                                      + wti_pkg::wide_t'(rnd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg        <= wti_pkg::NP_RESET;
            nj_reg        <= wti_pkg::NJ_RESET;
            seg_reg       <= '0;
            done_reg      <= 1'b0;
            fmode_reg     <= 1'b0;
            j_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == wti_pkg::CFG_NUM_POINTS)
                begin
                    np_reg <= cfg_data[wti_pkg::NPR_W-1:0];
                end
                else if (cfg_index == wti_pkg::CFG_NUM_JOINTS)
                begin
                    nj_reg <= cfg_data[wti_pkg::NJR_W-1:0];
                end
            end

            if (accept && (cmd == wti_pkg::CMD_RESTART))
            begin
                seg_reg  <= '0;
                done_reg <= 1'b0;
            end
            if (ctl.seg_inc)
            begin
                seg_reg <= seg_p1;
            end
            if (ctl.fin_start)
            begin
                done_reg  <= 1'b1;
                fmode_reg <= 1'b1;
                j_reg     <= '0;
            end
            if (ctl.frac_sel)
            begin
                fmode_reg <= 1'b0;
                j_reg     <= '0;
                dcnt_reg  <= '0;
                if (seg_reg >= last_seg)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (ctl.div_step)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (ctl.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= value;
        end
        if (ctl.t0_cap)
        begin
            t0_reg <= t_rdata;
        end
        if (ctl.nd_cap)
        begin
            num_reg <= wti_pkg::wide_t'(val_reg) - wti_pkg::wide_t'(t0_reg);
            den_reg <= wti_pkg::wide_t'(t_rdata) - wti_pkg::wide_t'(t0_reg);
        end
        if (ctl.fin_start)
        begin
            frac_reg <= '0;
        end
        if (ctl.frac_sel)
        begin
            rem_reg <= wti_pkg::rem_t'(num_reg);
            if (num_reg <= 0)
            begin
                frac_reg <= '0;
            end
            else if ((den_reg <= 0) || (num_reg >= den_reg))
            begin
                frac_reg <= wti_pkg::FRAC_ONE;
            end
            else
            begin
                frac_reg <= '0;
            end
        end
        if (ctl.div_step)
        begin
            rem_reg  <= div_ge ? wti_pkg::rem_t'(div_sh - {1'b0, den_reg})
                               : div_sh[wti_pkg::WIDE_W-1:0];
            frac_reg <= {frac_reg[wti_pkg::FRAC_W-2:0], div_ge};
        end
        if (ctl.p0_cap)
        begin
            p0_reg <= p_rdata;
        end
        if (ctl.p1_cap)
        begin
            // The final waypoint is emitted as is: no difference to scale.
            delta_reg <= fmode_reg ? '0
                                   : wti_pkg::wide_t'(p_rdata) - wti_pkg::wide_t'(p0_reg);
        end
        if (ctl.mul)
        begin
            prod_reg <= wti_pkg::prod_t'(delta_reg)
                        * wti_pkg::prod_t'($signed({1'b0, frac_reg}));
        end
        if (ctl.out_load)
        begin
            oj_reg    <= wti_pkg::jidx_t'(j_reg);
            opos_reg  <= pos_next;
            olast_reg <= j_last;
            ofin_reg  <= done_reg;
        end
    end

    always_comb
    begin
        st           = '0;
        st.is_sample = cmd == wti_pkg::CMD_SAMPLE;
        st.final_now = done_reg || (seg_reg >= last_seg);
        st.adv_gt    = val_reg > t_rdata;
        st.adv_more  = seg_p1 < last_seg;
        st.div_need  = (num_reg > 0) && (den_reg > 0) && (num_reg < den_reg);
        st.div_last  = dcnt_reg == wti_pkg::dcnt_t'(wti_pkg::QUO_W - 1);
        st.out_free  = out_free;
        st.j_last    = j_last;
    end

    assign out_valid       = out_valid_reg;
    assign out_joint       = oj_reg;
    assign target_position = opos_reg;
    assign last_joint      = olast_reg;
    assign finished        = ofin_reg;

endmodule

>>> hw/rtl/waypoint_trajectory_interpolator.sv
// Top level of the piecewise linear waypoint trajectory interpolator.
//
// The block holds a table of up to 64 waypoints, each with a time in microseconds and one
// Q16.16 position for each of up to 8 joints, and turns elapsed-time samples into one
// interpolated target position per joint. A transfer on the req channel carries a command:
// write a waypoint time, write a waypoint position, restart the trajectory, or give a time
// sample. Writes and restart leave the block idle and produce nothing. A sample first walks
// the current segment forward while the time lies past the segment's end waypoint, then
// forms the Q1.16 fraction and produces, joint by joint, one transfer on the rsp channel
// with the joint number, the position, a last-joint flag on the final joint and the
// finished flag. Once the last segment has been reached, finished is set and later samples
// return the final waypoint until a restart. The fraction comes from a bit-serial divider,
// used only when the time lies strictly inside the segment; a sample past the end skips
// the walk and the divide. Both waypoint tables sit in single-port-read RAMs with
// registered reads, and the joints are read one at a time through the one read port of
// the position RAM. A joint waits for the output register while the rsp channel stalls.
// A new item is taken only after the previous sample has handed its last joint to the
// output register, which may still hold it while the next item is taken. The user must
// see that num_points and num_joints are written through the cfg port only while the
// block is idle; the block itself does not enforce this. Values outside 2..64 and 1..8
// are clamped on use. Reading a waypoint that was never written returns an undefined
// position.
module waypoint_trajectory_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    wti_in_if.sink              req,
    wti_out_if.source           rsp,
    input  logic                cfg_we,
    input  wti_pkg::cfg_idx_t   cfg_index,
    input  wti_pkg::cfg_data_t  cfg_data
);

    // Command and status bundles between the sequencer and the datapath.
    wti_pkg::ctrl_t ctl;
    wti_pkg::stat_t st;

    // The input channel is open only while the sequencer waits for work.
    assign req.ready = ctl.ready;

    wti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .st       (st),
        .ctl      (ctl)
    );

    // The datapath owns the waypoint RAMs, the segment and done state, the divider, the
    // multiplier and the output register that feeds the rsp channel.
    wti_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (req.valid),
        .point_index     (req.point_index),
        .joint_index     (req.joint_index),
        .command         (req.command),
        .value           (req.value),
        .out_ready       (rsp.ready),
        .ctl             (ctl),
        .st              (st),
        .out_valid       (rsp.valid),
        .out_joint       (rsp.out_joint),
        .target_position (rsp.target_position),
        .last_joint      (rsp.last_joint),
        .finished        (rsp.finished)
    );

endmodule

>>> dv/tb_waypoint_trajectory_interpolator.sv
// Self-checking testbench of the waypoint trajectory interpolator with its own trajectory predictor.
`timescale 1ns / 1ps

module tb_waypoint_trajectory_interpolator;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int CFG_COUNT     = 9;

    // One item on the request channel, as the driver presents it.
    typedef struct packed {
        wti_pkg::cmd_t  command;
        wti_pkg::pidx_t point_index;
        wti_pkg::jidx_t joint_index;
        wti_pkg::val_t  value;
    } waypoint_cmd_t;

    // One joint target on the response channel.
    typedef struct packed {
        wti_pkg::jidx_t joint;
        wti_pkg::val_t  position;
        logic           last;
        logic           fin;
    } joint_target_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    wti_pkg::cfg_idx_t cfg_index;
    wti_pkg::cfg_data_t cfg_data;

    wti_in_if  req_if ();
    wti_out_if rsp_if ();

    waypoint_trajectory_interpolator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Commands waiting for the driver, and joint targets waiting for the DUT to produce them.
    waypoint_cmd_t cmd_queue[$];
    joint_target_t target_queue[$];
    waypoint_cmd_t next_cmd;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    // Predictor state: the waypoint table, the trajectory progress and the raw registers.
    wti_pkg::val_t wp_time [wti_pkg::MAX_POINTS];
    wti_pkg::val_t wp_pos  [wti_pkg::MAX_POINTS][wti_pkg::MAX_JOINTS];
    int unsigned seg_now;
    logic traj_done;
    wti_pkg::npr_t np_reg;
    wti_pkg::njr_t nj_reg;

    int unsigned mismatch_count;
    int unsigned sample_count;
    int unsigned write_count;
    int unsigned restart_count;
    int unsigned target_count;

    function automatic int clamp_count(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Works out the joint targets that one accepted command causes and updates the predictor
    // state. Writes and restart produce nothing; a sample produces one target per joint.
    function automatic void predict_targets(input waypoint_cmd_t c);
        int pts;
        int jnts;
        int last_seg;
        int j;
        longint num;
        longint den;
        longint frac;
        longint delta;
        joint_target_t t;

        pts      = clamp_count(int'(np_reg), 2, wti_pkg::MAX_POINTS);
        jnts     = clamp_count(int'(nj_reg), 1, wti_pkg::MAX_JOINTS);
        last_seg = pts - 2;

        case (c.command)
            wti_pkg::CMD_WR_TIME:
            begin
                wp_time[c.point_index] = c.value;
            end
            wti_pkg::CMD_WR_POS:
            begin
                wp_pos[c.point_index][c.joint_index] = c.value;
            end
            wti_pkg::CMD_RESTART:
            begin
                seg_now   = 0;
                traj_done = 1'b0;
            end
            default:
            begin
                if (traj_done || int'(seg_now) >= last_seg)
                begin
                    // Trajectory already at its end: hold the final waypoint.
                    traj_done = 1'b1;
                    for (j = 0; j < jnts; j++)
                    begin
                        t.joint    = wti_pkg::jidx_t'(j);
                        t.position = wp_pos[pts-1][j];
                        t.last     = (j == jnts - 1);
                        t.fin      = 1'b1;
                        target_queue.insert(target_queue.size(), t);
                    end
                end
                else
                begin
                    while (int'(seg_now) < last_seg && c.value > wp_time[seg_now+1])
                        seg_now++;

                    num = longint'(c.value) - longint'(wp_time[seg_now]);
                    den = longint'(wp_time[seg_now+1]) - longint'(wp_time[seg_now]);
                    if (num <= 0)
                        frac = 0;
                    else if (den <= 0 || num >= den)
                        frac = 65536;
                    else
                        frac = (num * 65536) / den;

                    if (int'(seg_now) >= last_seg)
                        traj_done = 1'b1;

                    for (j = 0; j < jnts; j++)
                    begin
                        delta = longint'(wp_pos[seg_now+1][j]) - longint'(wp_pos[seg_now][j]);
                        t.joint    = wti_pkg::jidx_t'(j);
                        t.position = wti_pkg::val_t'(longint'(wp_pos[seg_now][j])
                                                     + (delta * frac) / 65536);
                        t.last     = (j == jnts - 1);
                        t.fin      = traj_done;
                        target_queue.insert(target_queue.size(), t);
                    end
                end
            end
        endcase
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Request driver. A new command is offered only once the previous one has been taken,
    // so valid stays high across back-to-back transfers without being lowered in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_cmd = cmd_queue.pop_front();
                req_if.valid       <= 1'b1;
                req_if.command     <= next_cmd.command;
                req_if.point_index <= next_cmd.point_index;
                req_if.joint_index <= next_cmd.joint_index;
                req_if.value       <= next_cmd.value;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor. Each response transfer is checked against the oldest predicted target first;
    // then an accepted request transfer is fed to the predictor. Both sides are sampled at
    // the rising edge, before any of the edge's own updates land.
    always @(posedge clk)
    begin
        joint_target_t got;
        joint_target_t want;

        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.joint    = rsp_if.out_joint;
                got.position = rsp_if.target_position;
                got.last     = rsp_if.last_joint;
                got.fin      = rsp_if.finished;
                target_count++;
                if (target_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected target: joint %0d pos %0d last %0b fin %0b",
                                 $realtime, got.joint, got.position, got.last, got.fin);
                end
                else
                begin
                    want = target_queue.pop_front();
                    if (got.joint !== want.joint || got.position !== want.position ||
                        got.last !== want.last || got.fin !== want.fin)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: target mismatch: expected joint %0d pos %0d ",
                                      "last %0b fin %0b, got joint %0d pos %0d last %0b fin %0b"},
                                     $realtime, want.joint, want.position, want.last, want.fin,
                                     got.joint, got.position, got.last, got.fin);
                    end
                end
            end

            if (req_if.valid && req_if.ready)
            begin
                next_cmd_seen : begin
                    waypoint_cmd_t c;
                    c.command     = wti_pkg::cmd_t'(req_if.command);
                    c.point_index = req_if.point_index;
                    c.joint_index = req_if.joint_index;
                    c.value       = req_if.value;
                    case (c.command)
                        wti_pkg::CMD_SAMPLE:  sample_count++;
                        wti_pkg::CMD_RESTART: restart_count++;
                        default:              write_count++;
                    endcase
                    predict_targets(c);
                end
            end
        end
    end

    task automatic push_item(input wti_pkg::cmd_t cmd, input int pidx, input int jidx,
                             input wti_pkg::val_t v);
        waypoint_cmd_t c;
        c.command     = cmd;
        c.point_index = wti_pkg::pidx_t'(pidx);
        c.joint_index = wti_pkg::jidx_t'(jidx);
        c.value       = v;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    // Waits until every queued command has been taken and every target has come back,
    // then waits out SETTLE_CYCLES so that any write or restart in flight can finish.
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || req_if.valid || target_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever issued while the block is idle.
    task automatic write_register(input wti_pkg::cfg_idx_t idx, input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wti_pkg::cfg_data_t'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == wti_pkg::CFG_NUM_POINTS)
            np_reg = wti_pkg::npr_t'(v);
        else
            nj_reg = wti_pkg::njr_t'(v);
    endtask

    function automatic wti_pkg::val_t random_position();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return wti_pkg::val_t'(int'($urandom_range(200000)) - 100000);
            default: return wti_pkg::val_t'($urandom);
        endcase
    endfunction

    // Loads a fresh trajectory into the points and joints in use, then walks time through it
    // with mostly rising samples. About one item in eight is noise: a restart, a sample at a
    // random time, or a stray write anywhere in the table.
    task automatic run_trajectory(input int pts, input int jnts, input int n_samples);
        int t_pt [wti_pkg::MAX_POINTS];
        int t;
        int k;
        int j;
        int cursor;
        int span;
        int step_max;
        int r;

        t = int'($urandom_range(2000)) - 1000;
        for (k = 0; k < pts; k++)
        begin
            if (k > 0)
            begin
                r = $urandom_range(19);
                if (r == 0)
                    t = t;                                  // flat segment
                else if (r == 1)
                    t = t - int'($urandom_range(200));      // time running backward
                else if (r == 2)
                    t = t + 1;
                else
                    t = t + 1 + int'($urandom_range(4999));
            end
            t_pt[k] = t;
            push_item(wti_pkg::CMD_WR_TIME, k, $urandom_range(7), wti_pkg::val_t'(t));
        end
        for (k = 0; k < pts; k++)
            for (j = 0; j < jnts; j++)
                push_item(wti_pkg::CMD_WR_POS, k, j, random_position());
        push_item(wti_pkg::CMD_RESTART, $urandom_range(63), $urandom_range(7),
                  wti_pkg::val_t'($urandom));

        span     = t_pt[pts-1] - t_pt[0];
        step_max = (span > 0) ? span * 3 / n_samples + 10 : 5000;
        cursor   = t_pt[0] - int'($urandom_range(500));

        for (k = 0; k < n_samples; k++)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                push_item(wti_pkg::CMD_RESTART, $urandom_range(63), $urandom_range(7),
                          wti_pkg::val_t'($urandom));
                cursor = t_pt[0] - int'($urandom_range(500));
            end
            else if (r < 8)
            begin
                push_item(wti_pkg::CMD_SAMPLE, $urandom_range(63), $urandom_range(7),
                          wti_pkg::val_t'($urandom));
            end
            else if (r < 12)
            begin
                push_item(($urandom_range(1) == 0) ? wti_pkg::CMD_WR_TIME : wti_pkg::CMD_WR_POS,
                          $urandom_range(63), $urandom_range(7), wti_pkg::val_t'($urandom));
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    cursor = t_pt[$urandom_range(pts - 1)];   // land right on a waypoint
                else
                    cursor = cursor + int'($urandom_range(step_max));
                push_item(wti_pkg::CMD_SAMPLE, $urandom_range(63), $urandom_range(7),
                          wti_pkg::val_t'(cursor));
            end
        end

        // Finish off past the last waypoint, then once more on the finished trajectory.
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, wti_pkg::val_t'(t_pt[pts-1] + 1));
        push_item(wti_pkg::CMD_SAMPLE, 63, 7,
                  wti_pkg::val_t'(t_pt[pts-1] + int'($urandom_range(1000))));
    endtask

    // Run control: reset, a directed pass, then random trajectories under several register
    // settings and three idle mixes.
    initial
    begin
        int np_list [CFG_COUNT];
        int nj_list [CFG_COUNT];
        int ph;
        int k;
        int idx;

        np_list = '{3, 7, 2, 0, 6, 16, 5, 127, 1};
        nj_list = '{2, 8, 8, 15, 0, 1, 8, 1, 5};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = wti_pkg::CFG_NUM_POINTS;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.command     = wti_pkg::CMD_WR_TIME;
        req_if.point_index = '0;
        req_if.joint_index = '0;
        req_if.value       = '0;
        rsp_if.ready       = 1'b0;
        send_gap_pct       = 13;
        recv_stall_pct     = 84;
        seg_now            = 0;
        traj_done          = 1'b0;
        np_reg             = wti_pkg::NP_RESET;
        nj_reg             = wti_pkg::NJ_RESET;
        mismatch_count     = 0;
        sample_count       = 0;
        write_count        = 0;
        restart_count      = 0;
        target_count       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass: three waypoints, two joints. The first segment spans the full
        // position range in opposite directions; the second is flat in time.
        write_register(wti_pkg::CFG_NUM_POINTS, 3);
        write_register(wti_pkg::CFG_NUM_JOINTS, 2);
        push_item(wti_pkg::CMD_WR_TIME, 0, 0, 100);
        push_item(wti_pkg::CMD_WR_TIME, 1, 0, 100100);
        push_item(wti_pkg::CMD_WR_TIME, 2, 0, 100100);
        push_item(wti_pkg::CMD_WR_POS, 0, 0, 32'h8000_0000);
        push_item(wti_pkg::CMD_WR_POS, 1, 0, 32'h7fff_ffff);
        push_item(wti_pkg::CMD_WR_POS, 2, 0, 0);
        push_item(wti_pkg::CMD_WR_POS, 0, 1, 32'h7fff_ffff);
        push_item(wti_pkg::CMD_WR_POS, 1, 1, 32'h8000_0000);
        push_item(wti_pkg::CMD_WR_POS, 2, 1, 12345);
        // Top corner of the table: stored but never read under this setting.
        push_item(wti_pkg::CMD_WR_TIME, 63, 7, 32'h7fff_ffff);
        push_item(wti_pkg::CMD_WR_POS, 63, 7, 32'h8000_0000);
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 32'h8000_0000);   // long before the start
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 100);             // exactly on the start
        push_item(wti_pkg::CMD_SAMPLE, 63, 7, 50100);          // half way
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 100099);          // one step short of the end
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 100100);          // on the end, no advance
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 100101);          // into the flat last segment
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 5);               // finished: final waypoint
        push_item(wti_pkg::CMD_RESTART, 63, 7, -1);
        push_item(wti_pkg::CMD_SAMPLE, 0, 0, 32'h7fff_ffff);   // straight past the end
        push_item(wti_pkg::CMD_RESTART, 0, 0, 0);
        wait_drained();

        // Random pass: three register settings per idle mix. Settings include the clamped
        // values at both ends of each register.
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct   = 13;
                    recv_stall_pct = 84;
                end
                1:
                begin
                    send_gap_pct   = 84;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (k = 0; k < 3; k++)
            begin
                idx = ph * 3 + k;
                write_register(wti_pkg::CFG_NUM_POINTS, np_list[idx]);
                write_register(wti_pkg::CFG_NUM_JOINTS, nj_list[idx]);
                run_trajectory(clamp_count(np_list[idx], 2, wti_pkg::MAX_POINTS),
                               clamp_count(nj_list[idx], 1, wti_pkg::MAX_JOINTS),
                               $urandom_range(12, 20));
                wait_drained();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples, %0d table writes and %0d restarts over %0d settings.",
                 sample_count, write_count, restart_count, CFG_COUNT + 1);
        $display("Checked %0d joint targets under three idle mixes; %0d mismatches.",
                 target_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d commands and %0d targets outstanding.",
                 cmd_queue.size(), target_queue.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/wti_pkg.sv
hw/rtl/wti_in_if.sv
hw/rtl/wti_out_if.sv
hw/rtl/wti_ram.sv
hw/rtl/wti_ctrl.sv
hw/rtl/wti_dp.sv
hw/rtl/waypoint_trajectory_interpolator.sv
dv/tb_waypoint_trajectory_interpolator.sv
